// ===== src/idl_pkg.sv =====
// ----------------------------------------------------------------------------
// idl_pkg: shared types and constants of the indexed deque list
// Action, status and cell command codes, FSM state type and port widths.
// ----------------------------------------------------------------------------
package idl_pkg;

   localparam int ACTION_W    = 3;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int RSP_COUNT_W = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_GET        = 3'd4,
      ACT_SET        = 3'd5,
      ACT_SWAP       = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_SHIFT_UP,
      CMD_SHIFT_DOWN,
      CMD_LOAD
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         rd_load;
      logic         rd_shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

// ===== src/indexed_deque_list.sv =====
// ----------------------------------------------------------------------------
// indexed_deque_list: bounded ordered list with deque and indexed access
// Row of storage cells; push/pop at both ends, get, set and swap by position.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   Every transaction gives exactly one result: rsp_strobe is high for one
//   cycle with rsp_read_value, rsp_status and rsp_entry_count. The receiver
//   cannot stall; results must be taken when strobed.
// Result timing:
//   Push front, push back, pop front, set, refused actions and code 7:
//   result in the cycle after acceptance, busy stays low, one per cycle.
//   Get, pop back and swap drain a snapshot of all cells through the read
//   line toward cell 0, one cell per cycle. With p the deepest position
//   read (index for get, count-1 for pop back, larger index for swap),
//   busy stays high until the entry of cell p reaches cell 0, and the
//   result is registered from cell 0 at that point.
// Reset:
//   Synchronous, active high. Empties the list and drops any result in
//   flight; entry contents are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
module indexed_deque_list
   import idl_pkg::*;
#(
   parameter int CAPACITY     = 16,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic [INDEX_W-1:0]     req_index_a,
   input  logic [INDEX_W-1:0]     req_index_b,
   output logic                   rsp_strobe,
   output logic [VALUE_W-1:0]     rsp_read_value,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [RSP_COUNT_W-1:0] rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   action_type              act_ff, act_in;
   logic [POS_W-1:0]        pos_a_ff, pos_a_in;
   logic [POS_W-1:0]        pos_b_ff, pos_b_in;
   logic [POS_W-1:0]        last_ff, last_in;
   logic [POS_W-1:0]        step_ff, step_in;
   logic [ELEMENT_BITS-1:0] cap_a_ff, cap_a_in;
   logic [ELEMENT_BITS-1:0] cap_b_ff, cap_b_in;

   logic                    rsp_strobe_ff;
   logic [VALUE_W-1:0]      rsp_read_value_ff;
   status_type              rsp_status_ff;
   logic [RSP_COUNT_W-1:0]  rsp_entry_count_ff;

   logic                    accept, walk_go, rsp_fire;
   action_type              req_act;
   logic [ELEMENT_BITS-1:0] value_masked, rsp_rd;
   status_type              rsp_st;
   logic                    full, empty, bad_a, bad_b;
   logic [POS_W-1:0]        ia_pos, ib_pos, back_pos, back_last, max_pos;
   logic                    at_target, at_a, at_b;
   logic [ELEMENT_BITS-1:0] rd0, front_data, cur_a, cur_b;

   cell_ctrl_type           ctrl;
   logic [POS_W-1:0]        pos_a, pos_b;
   logic [ELEMENT_BITS-1:0] wr_a, wr_b;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && (state_ff == ST_IDLE);
   assign req_act      = action_type'(req_action);
   assign value_masked = ELEMENT_BITS'(req_value);

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign bad_a     = (CMP_W'(req_index_a) >= CMP_W'(count_ff));
   assign bad_b     = (CMP_W'(req_index_b) >= CMP_W'(count_ff));
   assign ia_pos    = POS_W'(req_index_a);
   assign ib_pos    = POS_W'(req_index_b);
   assign back_pos  = POS_W'(count_ff);
   assign back_last = POS_W'(count_ff - CNT_W'(1));
   assign max_pos   = (req_index_a > req_index_b) ? ia_pos : ib_pos;

   assign at_target = (step_ff == last_ff);
   assign at_a      = (step_ff == pos_a_ff);
   assign at_b      = (step_ff == pos_b_ff);
   assign cur_a     = at_a ? rd0 : cap_a_ff;
   assign cur_b     = at_b ? rd0 : cap_b_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && walk_go) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (at_target) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // cell commands, bookkeeping and result
   always_comb begin
      ctrl     = '{cmd: CMD_HOLD, rd_load: 1'b0, rd_shift: 1'b0};
      pos_a    = ia_pos;
      pos_b    = ia_pos;
      wr_a     = value_masked;
      wr_b     = value_masked;
      count_in = count_ff;
      walk_go  = 1'b0;
      act_in   = act_ff;
      pos_a_in = pos_a_ff;
      pos_b_in = pos_b_ff;
      last_in  = last_ff;
      step_in  = step_ff;
      cap_a_in = cap_a_ff;
      cap_b_in = cap_b_ff;
      rsp_fire = 1'b0;
      rsp_rd   = '0;
      rsp_st   = STAT_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_act;
               pos_a_in = ia_pos;
               pos_b_in = ib_pos;
               step_in  = '0;
               rsp_fire = 1'b1;
               case (req_act)
                  ACT_PUSH_FRONT: begin
                     if (full) begin
                        rsp_st = STAT_FULL;
                     end else begin
                        ctrl.cmd = CMD_SHIFT_UP;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (full) begin
                        rsp_st = STAT_FULL;
                     end else begin
                        ctrl.cmd = CMD_LOAD;
                        pos_a    = back_pos;
                        pos_b    = back_pos;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        rsp_st = STAT_EMPTY;
                     end else begin
                        rsp_rd   = front_data;
                        ctrl.cmd = CMD_SHIFT_DOWN;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_POP_BACK: begin
                     if (empty) begin
                        rsp_st = STAT_EMPTY;
                     end else begin
                        count_in     = count_ff - CNT_W'(1);
                        walk_go      = 1'b1;
                        rsp_fire     = 1'b0;
                        ctrl.rd_load = 1'b1;
                        last_in      = back_last;
                     end
                  end
                  ACT_GET: begin
                     if (bad_a) begin
                        rsp_st = STAT_BAD_INDEX;
                     end else begin
                        walk_go      = 1'b1;
                        rsp_fire     = 1'b0;
                        ctrl.rd_load = 1'b1;
                        last_in      = ia_pos;
                     end
                  end
                  ACT_SET: begin
                     if (bad_a) begin
                        rsp_st = STAT_BAD_INDEX;
                     end else begin
                        ctrl.cmd = CMD_LOAD;
                     end
                  end
                  ACT_SWAP: begin
                     if (bad_a || bad_b) begin
                        rsp_st = STAT_BAD_INDEX;
                     end else begin
                        walk_go      = 1'b1;
                        rsp_fire     = 1'b0;
                        ctrl.rd_load = 1'b1;
                        last_in      = max_pos;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (at_a) begin
               cap_a_in = rd0;
            end
            if (at_b) begin
               cap_b_in = rd0;
            end
            if (at_target) begin
               rsp_fire = 1'b1;
               if (act_ff == ACT_SWAP) begin
                  ctrl.cmd = CMD_LOAD;
                  pos_a    = pos_a_ff;
                  pos_b    = pos_b_ff;
                  wr_a     = cur_b;
                  wr_b     = cur_a;
               end else begin
                  rsp_rd = rd0;
               end
            end else begin
               ctrl.rd_shift = 1'b1;
               step_in       = step_ff + POS_W'(1);
            end
         end
         default: ;
      endcase
   end

   idl_chain #(
      .CAPACITY (CAPACITY),
      .DATA_W   (ELEMENT_BITS),
      .POS_W    (POS_W)
   ) u_chain (
      .clock       (clock),
      .ctrl        (ctrl),
      .pos_a       (pos_a),
      .pos_b       (pos_b),
      .wr_data_a   (wr_a),
      .wr_data_b   (wr_b),
      .front_value (value_masked),
      .front_data  (front_data),
      .rd_front    (rd0)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      act_ff             <= act_in;
      pos_a_ff           <= pos_a_in;
      pos_b_ff           <= pos_b_in;
      last_ff            <= last_in;
      step_ff            <= step_in;
      cap_a_ff           <= cap_a_in;
      cap_b_ff           <= cap_b_in;
      rsp_read_value_ff  <= VALUE_W'(rsp_rd);
      rsp_status_ff      <= rsp_st;
      rsp_entry_count_ff <= RSP_COUNT_W'(count_in);
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

// ===== src/idl_cell.sv =====
// ----------------------------------------------------------------------------
// idl_cell: one storage cell of the list
// Holds one entry and one stage of the read line; shifts with its neighbors.
// ----------------------------------------------------------------------------
module idl_cell
   import idl_pkg::*;
#(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic              hit_a,
   input  logic              hit_b,
   input  logic [DATA_W-1:0] wr_data_a,
   input  logic [DATA_W-1:0] wr_data_b,
   input  logic [DATA_W-1:0] data_below,
   input  logic [DATA_W-1:0] data_above,
   input  logic [DATA_W-1:0] rd_above,
   output logic [DATA_W-1:0] data_out,
   output logic [DATA_W-1:0] rd_out
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CMD_SHIFT_UP:   data_in = data_below;
         CMD_SHIFT_DOWN: data_in = data_above;
         CMD_LOAD: begin
            if (hit_a) begin
               data_in = wr_data_a;
            end else if (hit_b) begin
               data_in = wr_data_b;
            end
         end
         default:        data_in = data_ff;
      endcase
   end

   // read line: snapshot of all cells, then drains toward cell 0
   always_comb begin
      rd_in = rd_ff;
      if (ctrl.rd_load) begin
         rd_in = data_ff;
      end else if (ctrl.rd_shift) begin
         rd_in = rd_above;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data_out = data_ff;
   assign rd_out   = rd_ff;

endmodule

// ===== src/idl_chain.sv =====
// ----------------------------------------------------------------------------
// idl_chain: row of list cells
// Position decode for writes and neighbor wiring of data and read line.
// ----------------------------------------------------------------------------
module idl_chain
   import idl_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int DATA_W   = 32,
   parameter int POS_W    = 4
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [POS_W-1:0]  pos_a,
   input  logic [POS_W-1:0]  pos_b,
   input  logic [DATA_W-1:0] wr_data_a,
   input  logic [DATA_W-1:0] wr_data_b,
   input  logic [DATA_W-1:0] front_value,
   output logic [DATA_W-1:0] front_data,
   output logic [DATA_W-1:0] rd_front
);

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_rd   [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              hit_a, hit_b;
      logic [DATA_W-1:0] below, above, rd_up;

      assign hit_a = (pos_a == POS_W'(i));
      assign hit_b = (pos_b == POS_W'(i));

      if (i == 0) begin : g_first
         assign below = front_value;
      end else begin : g_inner_below
         assign below = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign above = '0;
         assign rd_up = '0;
      end else begin : g_inner_above
         assign above = cell_data[i+1];
         assign rd_up = cell_rd[i+1];
      end

      idl_cell #(
         .DATA_W (DATA_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .hit_a      (hit_a),
         .hit_b      (hit_b),
         .wr_data_a  (wr_data_a),
         .wr_data_b  (wr_data_b),
         .data_below (below),
         .data_above (above),
         .rd_above   (rd_up),
         .data_out   (cell_data[i]),
         .rd_out     (cell_rd[i])
      );
   end

   assign front_data = cell_data[0];
   assign rd_front   = cell_rd[0];

endmodule

// ===== src/idl_checker.sv =====
// ----------------------------------------------------------------------------
// idl_checker: port-level checks for the indexed deque list
// Result consistency and response timing, bound to the top level.
// ----------------------------------------------------------------------------
module idl_checker
   import idl_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [ACTION_W-1:0]    req_action,
   input logic                   rsp_strobe,
   input logic [VALUE_W-1:0]     rsp_read_value,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic [RSP_COUNT_W-1:0] rsp_entry_count
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobed right after reset");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STAT_FULL) |-> rsp_entry_count == RSP_COUNT_W'(CAPACITY))
      else $error("full status with list not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STAT_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with entries present");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STAT_OK) |-> rsp_read_value == '0)
      else $error("refused transaction returned data");

   a_push_back_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_PUSH_BACK) |=> rsp_strobe)
      else $error("push back result not in next cycle");

endmodule

bind indexed_deque_list idl_checker #(
   .CAPACITY (CAPACITY)
) u_idl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .rsp_strobe      (rsp_strobe),
   .rsp_read_value  (rsp_read_value),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);
